### rtl/core/airtime_duty_cycle_budget_top_macros.svh
// Assertion macros for the airtime budget checker.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef AIRTIME_DUTY_CYCLE_BUDGET_TOP_MACROS_SVH
`define AIRTIME_DUTY_CYCLE_BUDGET_TOP_MACROS_SVH

// Checked only outside reset
`define ADCB_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included
`define ADCB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/adcb_pkg.sv
// Shared types and constants for the airtime duty cycle budget block.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package adcb_pkg;

   localparam int OP_W       = 2;
   localparam int TIME_W     = 32;
   localparam int BUDGET_W   = 27;
   localparam int FACTOR_W   = 16;
   localparam int WINDOW_W   = 27;
   localparam int THRESH_W   = 16;
   localparam int Q_FRAC     = 8;
   localparam int Q_ONE      = 256;
   localparam int DIVISOR_W  = FACTOR_W + 1;
   localparam int DIVIDEND_W = TIME_W + Q_FRAC;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int SUM_W      = TIME_W + 1;
   localparam int N_W        = 16;
   localparam int PROD_W     = N_W + DIVISOR_W;
   localparam int STRETCH_W  = PROD_W - Q_FRAC;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 27'd3600000;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1000;

   typedef enum logic [OP_W-1:0] {
      OP_BEGIN = 2'd0,
      OP_CHECK = 2'd1,
      OP_START = 2'd2,
      OP_DONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FACTOR = 2'd0,
      REG_WINDOW = 2'd1,
      REG_THRESH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_REFILL,
      ST_SPEND,
      ST_SHORTFALL,
      ST_MULT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic refill;
      logic spend;
      logic shortfall;
      logic mult;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/core/adcb_req_if.sv
// Request channel: operation and millisecond time, valid/ready handshake.
// Depends on adcb_pkg.
`default_nettype none

interface adcb_req_if;
   logic                          valid;
   logic                          ready;
   logic [adcb_pkg::OP_W-1:0]     operation;
   logic [adcb_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output operation, output now_ms, input ready);
   modport sink   (input valid, input operation, input now_ms, output ready);
endinterface

`default_nettype wire

### rtl/core/adcb_rsp_if.sv
// Response channel: budget, next send time, send flag and airtime total.
// Depends on adcb_pkg.
`default_nettype none

interface adcb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [adcb_pkg::BUDGET_W-1:0] budget_ms;
   logic [adcb_pkg::TIME_W-1:0]   next_send_time;
   logic                          send_allowed;
   logic [adcb_pkg::TIME_W-1:0]   total_airtime_ms;

   modport source (output valid, output budget_ms, output next_send_time,
                   output send_allowed, output total_airtime_ms, input ready);
   modport sink   (input valid, input budget_ms, input next_send_time,
                   input send_allowed, input total_airtime_ms, output ready);
endinterface

`default_nettype wire

### rtl/core/airtime_duty_cycle_budget_top.sv
// Top level of the transmit airtime token bucket.
// Depends on adcb_pkg, adcb_req_if, adcb_rsp_if, adcb_csr, adcb_dp, adcb_ctrl.
//
//   port       role     handshake          word
//   req_ch     sink     valid/ready        operation, now_ms
//   rsp_ch     source   valid/ready        budget_ms, next_send_time,
//                                          send_allowed, total_airtime_ms
//   csr_*      slave    APB, pready = 1    3 registers at 0x0, 0x4, 0x8
//
// Begin, check and done run divide, refill, spend, shortfall, multiply and finish; send
// start skips divide. The two 40-step restoring dividers (refill, cap) run side by side.
// One word is in work at a time; a finished response waits in its register
// while the next word is taken.
// Reset is synchronous; state clears to zero and registers to their defaults.
`default_nettype none

module airtime_duty_cycle_budget_top #(
   parameter int unsigned RESERVE_MS = 100
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   adcb_req_if.sink                               req_ch,
   adcb_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [adcb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [adcb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [adcb_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   logic [adcb_pkg::FACTOR_W-1:0]  factor;
   logic [adcb_pkg::WINDOW_W-1:0]  window;
   logic [adcb_pkg::THRESH_W-1:0]  thresh;
   adcb_pkg::dp_cmd_type           cmd;
   adcb_pkg::dp_status_type        status;

   adcb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .factor  (factor),
      .window  (window),
      .thresh  (thresh)
   );

   adcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.operation),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   adcb_dp #(
      .RESERVE_MS (RESERVE_MS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_op               (req_ch.operation),
      .req_now              (req_ch.now_ms),
      .factor               (factor),
      .window               (window),
      .thresh               (thresh),
      .rsp_budget_ms        (rsp_ch.budget_ms),
      .rsp_next_send_time   (rsp_ch.next_send_time),
      .rsp_send_allowed     (rsp_ch.send_allowed),
      .rsp_total_airtime_ms (rsp_ch.total_airtime_ms)
   );

endmodule

`default_nettype wire

### rtl/core/adcb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on adcb_pkg for the operand widths and step count.
`default_nettype none

module adcb_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [adcb_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [adcb_pkg::DIVISOR_W-1:0]    divisor,
   output logic                                   done,
   output logic [adcb_pkg::DIVIDEND_W-1:0]        quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [adcb_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [adcb_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [adcb_pkg::DIVISOR_W-1:0]     dsr_ff, dsr_in;
   logic [adcb_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;

   logic [adcb_pkg::DIVISOR_W:0]       trial;
   logic [adcb_pkg::DIVISOR_W:0]       diff;
   logic                               fits;

   // quo_ff shifts the dividend out at the top and the quotient in at the bottom
   assign trial = {rem_ff, quo_ff[adcb_pkg::DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[adcb_pkg::DIVISOR_W-1:0] : trial[adcb_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[adcb_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == adcb_pkg::DIV_CNT_W'(adcb_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/core/adcb_csr.sv
// APB-style register file: budget factor, window length, send threshold.
// Depends on adcb_pkg for widths, reset values and register indexes.
`default_nettype none

module adcb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [adcb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [adcb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adcb_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready,
   output logic [adcb_pkg::FACTOR_W-1:0]          factor,
   output logic [adcb_pkg::WINDOW_W-1:0]          window,
   output logic [adcb_pkg::THRESH_W-1:0]          thresh
);

   logic [adcb_pkg::FACTOR_W-1:0]   factor_ff, factor_in;
   logic [adcb_pkg::WINDOW_W-1:0]   window_ff, window_in;
   logic [adcb_pkg::THRESH_W-1:0]   thresh_ff, thresh_in;
   logic [adcb_pkg::CSR_IDX_W-1:0]  index;
   logic                            wr_en;

   assign index = paddr[adcb_pkg::CSR_ADDR_W-1:2];
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      factor_in = factor_ff;
      window_in = window_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         case (index)
            adcb_pkg::REG_FACTOR: factor_in = pwdata[adcb_pkg::FACTOR_W-1:0];
            adcb_pkg::REG_WINDOW: window_in = pwdata[adcb_pkg::WINDOW_W-1:0];
            adcb_pkg::REG_THRESH: thresh_in = pwdata[adcb_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         adcb_pkg::REG_FACTOR: prdata = adcb_pkg::CSR_DATA_W'(factor_ff);
         adcb_pkg::REG_WINDOW: prdata = adcb_pkg::CSR_DATA_W'(window_ff);
         adcb_pkg::REG_THRESH: prdata = adcb_pkg::CSR_DATA_W'(thresh_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= adcb_pkg::FACTOR_RESET;
         window_ff <= adcb_pkg::WINDOW_RESET;
         thresh_ff <= adcb_pkg::THRESH_RESET;
      end else begin
         factor_ff <= factor_in;
         window_ff <= window_in;
         thresh_ff <= thresh_in;
      end
   end

   assign pready = 1'b1;
   assign factor = factor_ff;
   assign window = window_ff;
   assign thresh = thresh_ff;

endmodule

`default_nettype wire

### rtl/core/adcb_dp.sv
// Budget datapath: two serial dividers for refill and cap, budget state,
// shortfall multiply and the response word register.
// Depends on adcb_pkg and adcb_div.
`default_nettype none

module adcb_dp #(
   parameter int unsigned RESERVE_MS = 100
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire adcb_pkg::dp_cmd_type              cmd,
   output adcb_pkg::dp_status_type                status,
   input  wire logic [adcb_pkg::OP_W-1:0]         req_op,
   input  wire logic [adcb_pkg::TIME_W-1:0]       req_now,
   input  wire logic [adcb_pkg::FACTOR_W-1:0]     factor,
   input  wire logic [adcb_pkg::WINDOW_W-1:0]     window,
   input  wire logic [adcb_pkg::THRESH_W-1:0]     thresh,
   output logic [adcb_pkg::BUDGET_W-1:0]          rsp_budget_ms,
   output logic [adcb_pkg::TIME_W-1:0]            rsp_next_send_time,
   output logic                                   rsp_send_allowed,
   output logic [adcb_pkg::TIME_W-1:0]            rsp_total_airtime_ms
);

   localparam logic [adcb_pkg::N_W-1:0] RESERVE = adcb_pkg::N_W'(RESERVE_MS);

   // working word and budget state
   adcb_pkg::op_type                  op_ff, op_in;
   logic [adcb_pkg::TIME_W-1:0]       now_ff, now_in;
   logic [adcb_pkg::BUDGET_W-1:0]     budget_ff, budget_in;
   logic [adcb_pkg::TIME_W-1:0]       last_ff, last_in;
   logic [adcb_pkg::TIME_W-1:0]       next_ff, next_in;
   logic [adcb_pkg::TIME_W-1:0]       start_ff, start_in;
   logic [adcb_pkg::TIME_W-1:0]       total_ff, total_in;
   logic [adcb_pkg::TIME_W-1:0]       air_ff, air_in;
   logic                              push_ff, push_in;
   logic                              allowed_ff, allowed_in;
   logic [adcb_pkg::N_W-1:0]          n_ff, n_in;
   logic [adcb_pkg::STRETCH_W-1:0]    stretch_ff, stretch_in;

   // response word
   logic [adcb_pkg::BUDGET_W-1:0]     out_budget_ff, out_budget_in;
   logic [adcb_pkg::TIME_W-1:0]       out_next_ff, out_next_in;
   logic                              out_allowed_ff, out_allowed_in;
   logic [adcb_pkg::TIME_W-1:0]       out_total_ff, out_total_in;

   logic [adcb_pkg::DIVISOR_W-1:0]    divisor;
   logic [adcb_pkg::TIME_W-1:0]       elapsed;
   logic [adcb_pkg::DIVIDEND_W-1:0]   dividend_a, dividend_b;
   logic [adcb_pkg::DIVIDEND_W-1:0]   quo_a, quo_b;
   logic                              done_a, done_b;
   logic [adcb_pkg::TIME_W-1:0]       refill;
   logic [adcb_pkg::BUDGET_W-1:0]     cap;
   logic [adcb_pkg::SUM_W-1:0]        sum;
   logic [adcb_pkg::BUDGET_W-1:0]     capped;
   logic [adcb_pkg::N_W-1:0]          limit;
   logic [adcb_pkg::TIME_W-1:0]       since_next;
   logic [adcb_pkg::PROD_W-1:0]       prod;

   // 1 / duty = (256 + factor) / 256
   assign divisor    = adcb_pkg::DIVISOR_W'(factor) + adcb_pkg::DIVISOR_W'(adcb_pkg::Q_ONE);
   assign elapsed    = req_now - last_ff;
   assign dividend_a = {elapsed, {adcb_pkg::Q_FRAC{1'b0}}};
   assign dividend_b = {{(adcb_pkg::DIVIDEND_W - adcb_pkg::WINDOW_W - adcb_pkg::Q_FRAC){1'b0}},
                        window, {adcb_pkg::Q_FRAC{1'b0}}};

   adcb_div u_div_refill (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend_a),
      .divisor  (divisor),
      .done     (done_a),
      .quotient (quo_a)
   );

   adcb_div u_div_cap (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend_b),
      .divisor  (divisor),
      .done     (done_b),
      .quotient (quo_b)
   );

   assign status.div_done = done_a && done_b;

   // quotients never exceed their undivided inputs, so the upper bits are zero
   assign refill = quo_a[adcb_pkg::TIME_W-1:0];
   assign cap    = quo_b[adcb_pkg::BUDGET_W-1:0];
   assign sum    = adcb_pkg::SUM_W'(budget_ff) + adcb_pkg::SUM_W'(refill);
   assign capped = (sum > adcb_pkg::SUM_W'(cap)) ? cap : sum[adcb_pkg::BUDGET_W-1:0];

   assign limit      = (op_ff == adcb_pkg::OP_CHECK) ? thresh : RESERVE;
   assign since_next = now_ff - next_ff;
   assign prod       = adcb_pkg::PROD_W'(n_ff) * adcb_pkg::PROD_W'(divisor);

   always_comb begin
      op_in          = op_ff;
      now_in         = now_ff;
      budget_in      = budget_ff;
      last_in        = last_ff;
      next_in        = next_ff;
      start_in       = start_ff;
      total_in       = total_ff;
      air_in         = air_ff;
      push_in        = push_ff;
      allowed_in     = allowed_ff;
      n_in           = n_ff;
      stretch_in     = stretch_ff;
      out_budget_in  = out_budget_ff;
      out_next_in    = out_next_ff;
      out_allowed_in = out_allowed_ff;
      out_total_in   = out_total_ff;

      if (cmd.load) begin
         op_in  = adcb_pkg::op_type'(req_op);
         now_in = req_now;
      end

      if (cmd.refill) begin
         air_in = now_ff - start_ff;
         case (op_ff)
            adcb_pkg::OP_BEGIN: begin
               budget_in = cap;
               last_in   = now_ff;
            end
            adcb_pkg::OP_CHECK, adcb_pkg::OP_DONE: begin
               if (refill != '0) begin
                  budget_in = capped;
                  last_in   = now_ff;
               end
            end
            adcb_pkg::OP_START: start_in = now_ff;
            default: ;
         endcase
      end

      if (cmd.spend && (op_ff == adcb_pkg::OP_DONE)) begin
         total_in = total_ff + air_ff;
         if (air_ff > adcb_pkg::TIME_W'(budget_ff))
            budget_in = '0;
         else
            budget_in = budget_ff - air_ff[adcb_pkg::BUDGET_W-1:0];
      end

      if (cmd.shortfall) begin
         push_in    = budget_ff < adcb_pkg::BUDGET_W'(limit);
         n_in       = limit - budget_ff[adcb_pkg::N_W-1:0];
         // signed compare across the wrap: now strictly after next send time
         allowed_in = (op_ff == adcb_pkg::OP_CHECK) && !push_in &&
                      (since_next != '0) && !since_next[adcb_pkg::TIME_W-1];
      end

      if (cmd.mult)
         stretch_in = prod[adcb_pkg::PROD_W-1:adcb_pkg::Q_FRAC];

      if (cmd.finish) begin
         case (op_ff)
            adcb_pkg::OP_BEGIN: next_in = now_ff;
            adcb_pkg::OP_CHECK: begin
               if (push_ff)
                  next_in = now_ff + adcb_pkg::TIME_W'(stretch_ff);
            end
            adcb_pkg::OP_DONE:
               next_in = push_ff ? now_ff + adcb_pkg::TIME_W'(stretch_ff) : now_ff;
            default: ;
         endcase
         out_budget_in  = budget_ff;
         out_next_in    = next_in;
         out_allowed_in = allowed_ff;
         out_total_in   = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         last_ff   <= '0;
         next_ff   <= '0;
         start_ff  <= '0;
         total_ff  <= '0;
      end else begin
         budget_ff <= budget_in;
         last_ff   <= last_in;
         next_ff   <= next_in;
         start_ff  <= start_in;
         total_ff  <= total_in;
      end
      op_ff          <= op_in;
      now_ff         <= now_in;
      air_ff         <= air_in;
      push_ff        <= push_in;
      allowed_ff     <= allowed_in;
      n_ff           <= n_in;
      stretch_ff     <= stretch_in;
      out_budget_ff  <= out_budget_in;
      out_next_ff    <= out_next_in;
      out_allowed_ff <= out_allowed_in;
      out_total_ff   <= out_total_in;
   end

   assign rsp_budget_ms        = out_budget_ff;
   assign rsp_next_send_time   = out_next_ff;
   assign rsp_send_allowed     = out_allowed_ff;
   assign rsp_total_airtime_ms = out_total_ff;

endmodule

`default_nettype wire

### rtl/core/adcb_ctrl.sv
// Sequencer for one request word: divide (skipped for a send start), refill, spend,
// shortfall, multiply, finish; owns the handshakes. Depends on adcb_pkg.
`default_nettype none

module adcb_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [adcb_pkg::OP_W-1:0]   req_op,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output adcb_pkg::dp_cmd_type             cmd,
   input  wire adcb_pkg::dp_status_type     status
);

   adcb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adcb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         adcb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // a send start needs no refill or cap
               if (req_op == adcb_pkg::OP_START) begin
                  state_in = adcb_pkg::ST_REFILL;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = adcb_pkg::ST_DIVIDE;
               end
            end
         end
         adcb_pkg::ST_DIVIDE: begin
            if (status.div_done)
               state_in = adcb_pkg::ST_REFILL;
         end
         adcb_pkg::ST_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = adcb_pkg::ST_SPEND;
         end
         adcb_pkg::ST_SPEND: begin
            cmd.spend = 1'b1;
            state_in  = adcb_pkg::ST_SHORTFALL;
         end
         adcb_pkg::ST_SHORTFALL: begin
            cmd.shortfall = 1'b1;
            state_in      = adcb_pkg::ST_MULT;
         end
         adcb_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = adcb_pkg::ST_FINISH;
         end
         adcb_pkg::ST_FINISH: begin
            // output register free, or emptied at this edge
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = adcb_pkg::ST_IDLE;
            end
         end
         default: state_in = adcb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)
         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/adcb_checker.sv
// Port-level checks for the airtime budget top, attached by bind.
// Depends on adcb_pkg and airtime_duty_cycle_budget_top_macros.svh.
`default_nettype none

`include "airtime_duty_cycle_budget_top_macros.svh"

module adcb_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [adcb_pkg::BUDGET_W-1:0]     rsp_budget_ms,
   input  wire logic [adcb_pkg::TIME_W-1:0]       rsp_next_send_time,
   input  wire logic                              rsp_send_allowed,
   input  wire logic [adcb_pkg::TIME_W-1:0]       rsp_total_airtime_ms
);

   logic       req_fire;
   logic       rsp_fire;
   logic       stalled;
   logic [1:0] pending_ff, pending_in;
   logic [adcb_pkg::BUDGET_W+2*adcb_pkg::TIME_W:0] rsp_word;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign stalled  = rsp_valid && !rsp_ready;
   assign rsp_word = {rsp_budget_ms, rsp_next_send_time, rsp_send_allowed,
                      rsp_total_airtime_ms};

   // words accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire)
         pending_in = pending_ff + 2'd1;
      else if (!req_fire && rsp_fire)
         pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         pending_ff <= '0;
      else
         pending_ff <= pending_in;
   end

   `ADCB_ASSERT_RST(a_rsp_hold, stalled |=> rsp_valid && $stable(rsp_word), "stalled word changed")
   `ADCB_ASSERT_RST(a_busy_after_accept, req_fire |=> !req_ready, "accepted while busy")
   `ADCB_ASSERT_RST(a_no_invented_rsp, rsp_valid |-> pending_ff != 2'd0, "unrequested response")
   `ADCB_ASSERT_RST(a_depth_two, !(req_fire && pending_ff == 2'd2), "over two words in flight")
   `ADCB_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind airtime_duty_cycle_budget_top adcb_checker u_adcb_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_budget_ms        (rsp_ch.budget_ms),
   .rsp_next_send_time   (rsp_ch.next_send_time),
   .rsp_send_allowed     (rsp_ch.send_allowed),
   .rsp_total_airtime_ms (rsp_ch.total_airtime_ms)
);

`default_nettype wire
